@@ design/pdrb_pkg.sv @@
// Shared types and constants for the Pelco-D rangefinder bridge.
package pdrb_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    OP_BUS     = 2'd0,
    OP_RF      = 2'd1,
    OP_TICK    = 2'd2,
    OP_BUS_ERR = 2'd3
  } op_t;

  // Exchange phase with the rangefinder
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RANGE = 2'd1,
    PH_POINT = 2'd2
  } phase_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 2'd1;

  localparam logic [7:0]  OWN_ADDRESS_RST = 8'd2;
  localparam logic [15:0] TIMEOUT_RST     = 16'd2000;

  // Bus frame bytes and commands
  localparam logic [7:0] BUS_SYNC      = 8'hFF;
  localparam logic [7:0] CMD_RANGE     = 8'h01;
  localparam logic [7:0] CMD_POINT     = 8'h02;
  localparam logic [7:0] ANS_OK        = 8'h00;
  localparam logic [7:0] ANS_NO_TARGET = 8'h01;
  localparam logic [7:0] ANS_ERROR     = 8'h02;

  // Rangefinder link bytes
  localparam logic [7:0] RF_HDR       = 8'h59;
  localparam logic [7:0] RF_RANGE_CMD = 8'hCC;
  localparam logic [7:0] RF_POINT_CMD = 8'hC5;
  localparam logic [7:0] RF_ACK_TAG   = 8'h3C;
  localparam logic [7:0] RF_SUM_XOR   = 8'h50;
  localparam logic [7:0] PTR_ON_CODE  = 8'h02;
  localparam logic [7:0] ST_NO_TARGET = 8'h20;
  localparam logic [7:0] ST_ERR_MASK  = 8'h10 | 8'h04;

  // Reply byte positions
  localparam logic [4:0] RANGE_LAST_IDX   = 5'd21;
  localparam logic [4:0] POINT_LAST_IDX   = 5'd3;
  localparam logic [4:0] RANGE_STATUS_IDX = 5'd20;
  localparam logic [4:0] DIST_FIRST_IDX   = 5'd2;
  localparam logic [4:0] DIST_LAST_IDX    = 5'd5;

  localparam logic [2:0] BUS_FRAME_LEN = 3'd7;
  localparam logic [2:0] BUS_LAST_IDX  = 3'd6;
  localparam logic [2:0] RANGE_REQ_LEN = 3'd5;
  localparam logic [2:0] POINT_REQ_LEN = 3'd3;

  localparam logic [15:0] DM_MAX = 16'hFFFF;

  // Outgoing frame handed to the transmitter
  typedef struct packed {
    logic            port;
    logic [2:0]      len;
    logic [6:0][7:0] bytes;
  } frame_t;

endpackage

@@ design/pdrb_dm_conv.sv @@
// Float32 metres to clamped 16-bit decimetres, registered.
module pdrb_dm_conv (
  input  logic        clk,
  input  logic [31:0] dist_bits,
  output logic [15:0] dm
);
  import pdrb_pkg::*;

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [27:0] prod;
  logic        big;
  logic [23:0] q;
  logic [3:0]  rem;
  logic [3:0]  half;
  logic        rnd;
  logic [24:0] qr;
  logic [8:0]  es;
  logic [8:0]  shr;
  logic [24:0] shifted;
  logic [15:0] dm_next;

  // Multiply by ten, round to 24 bits, then scale down and clamp
  always_comb begin
    sign    = dist_bits[31];
    expo    = dist_bits[30:23];
    frac    = dist_bits[22:0];
    mant    = {1'b1, frac};
    prod    = {1'b0, mant, 3'b000} + {3'b000, mant, 1'b0};
    big     = prod[27];
    q       = big ? prod[27:4] : prod[26:3];
    rem     = big ? prod[3:0] : {1'b0, prod[2:0]};
    half    = big ? 4'd8 : 4'd4;
    rnd     = (rem > half) || ((rem == half) && q[0]);
    qr      = {1'b0, q} + {24'd0, rnd};
    es      = {1'b0, expo} + (big ? 9'd4 : 9'd3);
    shr     = 9'd150 - es;
    shifted = qr >> shr[4:0];
    if (expo == 8'hFF) begin
      dm_next = ((frac != 23'd0) || sign) ? 16'd0 : DM_MAX;
    end else if (sign || (expo == 8'd0)) begin
      dm_next = 16'd0;
    end else if (es >= 9'd150) begin
      dm_next = DM_MAX;
    end else if (shr >= 9'd26) begin
      dm_next = 16'd0;
    end else if (shifted > {9'd0, DM_MAX}) begin
      dm_next = DM_MAX;
    end else begin
      dm_next = shifted[15:0];
    end
  end

  // Hold the result for the final reply byte
  always_ff @(posedge clk) begin
    dm <= dm_next;
  end

endmodule

@@ design/pdrb_tx.sv @@
// Frame transmitter: plays out one buffered frame a byte per transaction.
module pdrb_tx (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  pdrb_pkg::frame_t frame,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            port,
  output logic [7:0]      out_byte,
  output logic            last
);
  import pdrb_pkg::*;

  frame_t     frm;
  logic       busy;
  logic [2:0] idx;

  // Drive the current byte from the frame buffer
  always_comb begin
    out_valid = busy;
    port      = frm.port;
    out_byte  = frm.bytes[idx];
    last      = (idx == (frm.len - 3'd1));
    can_load  = !busy || (out_ready && last);
  end

  // Load a new frame or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm <= frame;
    end
  end

endmodule

@@ design/pelco_d_rangefinder_bridge_unit.sv @@
// Pelco-D bus to rangefinder bridge: framing, exchange control and answers.
// Flow: an item is registered on acceptance and processed from that register;
// any frame it causes is buffered in the transmitter, which offers its first byte.
// Throughput: one item per cycle; an item that starts a frame waits while
// the previous frame (3, 5 or 7 bytes, one per output transaction) drains.
// Reset (synchronous): clears framing and exchange state, own_address = 2,
// timeout_ticks = 2000; no clearing pass.
module pelco_d_rangefinder_bridge_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pdrb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [7:0]                       data,
  input  logic                             bus_idle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             port,
  output logic [7:0]                       out_byte,
  output logic                             last
);
  import pdrb_pkg::*;

  // Configuration
  logic [7:0]  own_address;
  logic [15:0] timeout_ticks;

  // Input register
  logic       in_q_valid;
  op_t        op_q;
  logic [7:0] data_q;
  logic       idle_q;

  // Block state
  logic [2:0]      bus_count, bus_count_next;
  logic [4:0][7:0] bus_frame, bus_frame_next;
  logic            start_ok, start_ok_next;
  phase_t          phase, phase_next;
  logic [4:0]      reply_count, reply_count_next;
  logic [7:0]      reply_sum, reply_sum_next;
  logic            reply_good, reply_good_next;
  logic [31:0]     distance_bits, distance_bits_next;
  logic [7:0]      status_flags, status_flags_next;
  logic            pointer_on, pointer_on_next;
  logic [15:0]     wait_timer, wait_timer_next;

  // Processing signals
  logic        busy;
  logic        emit;
  frame_t      frame;
  logic        can_load;
  logic        advance;
  logic [15:0] dm;
  logic [7:0]  fsum;
  logic [7:0]  pv;
  logic [7:0]  c1;
  logic [7:0]  c2;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic [7:0]  asum;
  logic [4:0]  last_idx;
  logic [15:0] wt;
  logic [15:0] limit;
  logic [2:0]  cnt_new;
  logic [1:0]  dsel;

  pdrb_dm_conv u_conv (
    .clk       (clk),
    .dist_bits (distance_bits),
    .dm        (dm)
  );

  pdrb_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .frame     (frame),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .port      (port),
    .out_byte  (out_byte),
    .last      (last)
  );

  assign advance  = in_q_valid && (!emit || can_load);
  assign in_ready = !in_q_valid || advance;
  assign busy     = (phase == PH_RANGE) || (phase == PH_POINT);

  // Process the registered item
  always_comb begin
    bus_count_next     = bus_count;
    bus_frame_next     = bus_frame;
    start_ok_next      = start_ok;
    phase_next         = phase;
    reply_count_next   = reply_count;
    reply_sum_next     = reply_sum;
    reply_good_next    = reply_good;
    distance_bits_next = distance_bits;
    status_flags_next  = status_flags;
    pointer_on_next    = pointer_on;
    wait_timer_next    = wait_timer;
    emit               = 1'b0;
    frame.port         = 1'b0;
    frame.len          = BUS_FRAME_LEN;
    frame.bytes        = '0;
    fsum     = bus_frame[0] + bus_frame[1] + bus_frame[2] + bus_frame[3] + bus_frame[4];
    pv       = pointer_on_next ? PTR_ON_CODE : 8'h00;
    c1       = ANS_OK;
    c2       = CMD_POINT;
    d1       = {7'd0, pointer_on};
    d2       = 8'h00;
    asum     = 8'h00;
    last_idx = (phase == PH_RANGE) ? RANGE_LAST_IDX : POINT_LAST_IDX;
    wt       = (wait_timer == 16'hFFFF) ? wait_timer : wait_timer + 16'd1;
    limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    cnt_new  = bus_count + 3'd1;
    dsel     = 2'(reply_count - DIST_FIRST_IDX);

    case (op_q)
      OP_BUS: begin
        // Collect frame bytes; close at seven bytes or a silent bus
        if (bus_count == 3'd0) begin
          start_ok_next = (data_q == BUS_SYNC);
        end else if (bus_count != BUS_LAST_IDX) begin
          bus_frame_next[bus_count - 3'd1] = data_q;
        end
        if ((cnt_new < BUS_FRAME_LEN) && !idle_q) begin
          bus_count_next = cnt_new;
        end else begin
          bus_count_next = 3'd0;
        end
        if ((bus_count == BUS_LAST_IDX) && start_ok && !busy &&
            (bus_frame[0] == own_address) && (fsum == data_q)) begin
          if (bus_frame[2] == CMD_RANGE) begin
            emit           = 1'b1;
            frame.port     = 1'b1;
            frame.len      = RANGE_REQ_LEN;
            frame.bytes[0] = RF_RANGE_CMD;
            frame.bytes[4] = RF_RANGE_CMD ^ RF_SUM_XOR;
            phase_next     = PH_RANGE;
          end else if (bus_frame[2] == CMD_POINT) begin
            pointer_on_next = (bus_frame[3] != 8'h00);
            pv              = pointer_on_next ? PTR_ON_CODE : 8'h00;
            emit            = 1'b1;
            frame.port      = 1'b1;
            frame.len       = POINT_REQ_LEN;
            frame.bytes[0]  = RF_POINT_CMD;
            frame.bytes[1]  = pv;
            frame.bytes[2]  = (RF_POINT_CMD + pv) ^ RF_SUM_XOR;
            phase_next      = PH_POINT;
          end
          if (emit) begin
            reply_count_next = 5'd0;
            reply_sum_next   = 8'h00;
            reply_good_next  = 1'b1;
            wait_timer_next  = 16'd0;
          end
        end
      end
      OP_RF: begin
        if (busy) begin
          if (reply_count >= last_idx) begin
            // Final byte: check the sum and answer on the bus
            phase_next       = PH_IDLE;
            reply_count_next = 5'd0;
            if (phase == PH_RANGE) begin
              c2 = CMD_RANGE;
              d1 = dm[7:0];
              d2 = dm[15:8];
              if ((status_flags & ST_NO_TARGET) != 8'h00) begin
                c1 = ANS_NO_TARGET;
              end else if ((status_flags & ST_ERR_MASK) != 8'h00) begin
                c1 = ANS_ERROR;
              end
            end
            asum = own_address + c1 + c2 + d1 + d2;
            if (reply_good && ((reply_sum ^ RF_SUM_XOR) == data_q)) begin
              emit           = 1'b1;
              frame.port     = 1'b0;
              frame.len      = BUS_FRAME_LEN;
              frame.bytes[0] = BUS_SYNC;
              frame.bytes[1] = own_address;
              frame.bytes[2] = c1;
              frame.bytes[3] = c2;
              frame.bytes[4] = d1;
              frame.bytes[5] = d2;
              frame.bytes[6] = asum;
            end
          end else begin
            // Check header bytes and capture payload
            if ((reply_count == 5'd0) && (data_q != RF_HDR)) begin
              reply_good_next = 1'b0;
            end
            if (phase == PH_RANGE) begin
              if ((reply_count == 5'd1) && (data_q != RF_RANGE_CMD)) begin
                reply_good_next = 1'b0;
              end
              if ((reply_count >= DIST_FIRST_IDX) && (reply_count <= DIST_LAST_IDX)) begin
                distance_bits_next[8*dsel +: 8] = data_q;
              end
              if (reply_count == RANGE_STATUS_IDX) begin
                status_flags_next = data_q;
              end
            end else begin
              if ((reply_count == 5'd1) && (data_q != RF_POINT_CMD)) begin
                reply_good_next = 1'b0;
              end
              if ((reply_count == 5'd2) && (data_q != RF_ACK_TAG)) begin
                reply_good_next = 1'b0;
              end
            end
            reply_sum_next   = reply_sum + data_q;
            reply_count_next = reply_count + 5'd1;
          end
        end
      end
      OP_TICK: begin
        // Count ticks and abandon the exchange at the limit
        if (busy) begin
          wait_timer_next = wt;
          if (wt >= limit) begin
            phase_next       = PH_IDLE;
            reply_count_next = 5'd0;
          end
        end
      end
      default: begin
        // Bus error: drop the partial frame
        bus_count_next = 3'd0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= OWN_ADDRESS_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS: own_address   <= cfg_data[7:0];
        REG_TIMEOUT:     timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(op);
      data_q <= data;
      idle_q <= bus_idle;
    end
  end

  // Commit state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_count    <= 3'd0;
      start_ok     <= 1'b0;
      phase        <= PH_IDLE;
      reply_count  <= 5'd0;
      reply_sum    <= 8'h00;
      reply_good   <= 1'b1;
      status_flags <= 8'h00;
      pointer_on   <= 1'b0;
      wait_timer   <= 16'd0;
    end else if (advance) begin
      bus_count    <= bus_count_next;
      start_ok     <= start_ok_next;
      phase        <= phase_next;
      reply_count  <= reply_count_next;
      reply_sum    <= reply_sum_next;
      reply_good   <= reply_good_next;
      status_flags <= status_flags_next;
      pointer_on   <= pointer_on_next;
      wait_timer   <= wait_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bus_frame     <= bus_frame_next;
      distance_bits <= distance_bits_next;
    end
  end

endmodule

@@ dv/tb_pelco_d_rangefinder_bridge_unit.sv @@
// Self-checking testbench for the Pelco-D rangefinder bridge unit.
`timescale 1ns / 1ps

module tb_pelco_d_rangefinder_bridge_unit;
  import pdrb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic PORT_BUS = 1'b0;
  localparam logic PORT_RF  = 1'b1;
  localparam logic [7:0] ST_FAULT_HI = 8'h10;
  localparam logic [7:0] ST_FAULT_LO = 8'h04;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int NUM_PHASES      = 6;
  localparam int TAIL_CYCLES     = 12;

  typedef struct {
    op_t        kind;
    logic [7:0] value;
    logic       idle;
  } bridge_item_t;

  typedef struct {
    logic       port;
    logic [7:0] value;
    logic       last;
  } link_byte_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             op = OP_BUS;
  logic [7:0]             data = '0;
  logic                   bus_idle = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   port;
  logic [7:0]             out_byte;
  logic                   last;

  bridge_item_t pending_items[$];
  link_byte_t   bytes_due[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 74;
  int mismatches    = 0;
  int items_taken   = 0;
  int bytes_checked = 0;
  int answers_seen  = 0;
  int settings_run  = 1;

  // Shadow of the bridge: registers, framing and exchange state
  logic [7:0]  own_addr_q = OWN_ADDRESS_RST;
  logic [15:0] timeout_q = TIMEOUT_RST;
  int unsigned bus_fill = 0;
  logic [7:0]  frame_b [6] = '{default: 8'd0};
  logic        sync_seen = 1'b0;
  phase_t      xchg_phase = PH_IDLE;
  int unsigned rx_count = 0;
  logic [7:0]  rx_sum = '0;
  logic        rx_good = 1'b1;
  logic [31:0] metres_bits = '0;
  logic [7:0]  rf_status = '0;
  logic        pointer_lit = 1'b0;
  logic [15:0] tick_count = '0;

  pelco_d_rangefinder_bridge_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data      (data),
    .bus_idle  (bus_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .port      (port),
    .out_byte  (out_byte),
    .last      (last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Metres as float32 bits to clamped decimetres, one rounding on the x10
  function automatic logic [15:0] metres_to_dm(logic [31:0] f);
    logic [27:0] prod;
    logic [27:0] rem;
    logic [27:0] half;
    logic [31:0] mant;
    int unsigned sh;
    int          scale;
    if (f[30:23] == 8'hFF) return (f[22:0] != 0 || f[31]) ? 16'd0 : DM_MAX;
    if (f[31] || f[30:23] == 8'h00) return 16'd0;
    prod = {4'd0, 1'b1, f[22:0]} * 28'd10;
    sh = prod[27] ? 4 : 3;
    mant = 32'(prod >> sh);
    rem = prod & ((28'd1 << sh) - 28'd1);
    half = 28'd1 << (sh - 1);
    if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
    scale = int'(f[30:23]) - 150 + int'(sh);
    if (scale >= 0) return DM_MAX;
    if (scale <= -26) return 16'd0;
    mant = mant >> (-scale);
    return (mant > 32'd65535) ? DM_MAX : mant[15:0];
  endfunction

  function automatic void owe_byte(logic p, logic [7:0] v, logic l);
    link_byte_t b;
    b.port = p;
    b.value = v;
    b.last = l;
    bytes_due.push_back(b);
  endfunction

  function automatic void owe_bus_answer(logic [7:0] c1, logic [7:0] c2,
                                         logic [7:0] d1, logic [7:0] d2);
    logic [7:0] ck;
    ck = own_addr_q + c1 + c2 + d1 + d2;
    owe_byte(PORT_BUS, BUS_SYNC, 1'b0);
    owe_byte(PORT_BUS, own_addr_q, 1'b0);
    owe_byte(PORT_BUS, c1, 1'b0);
    owe_byte(PORT_BUS, c2, 1'b0);
    owe_byte(PORT_BUS, d1, 1'b0);
    owe_byte(PORT_BUS, d2, 1'b0);
    owe_byte(PORT_BUS, ck, 1'b1);
  endfunction

  function automatic void start_wait(phase_t p);
    xchg_phase = p;
    rx_count = 0;
    rx_sum = '0;
    rx_good = 1'b1;
    tick_count = '0;
  endfunction

  // Complete 7-byte frame with a sync byte: check address and sum, then run it
  function automatic void accept_command();
    logic [7:0] s;
    logic [7:0] pv;
    s = frame_b[0] + frame_b[1] + frame_b[2] + frame_b[3] + frame_b[4];
    if (frame_b[0] != own_addr_q || s != frame_b[5]) return;
    if (frame_b[2] == CMD_RANGE) begin
      owe_byte(PORT_RF, RF_RANGE_CMD, 1'b0);
      owe_byte(PORT_RF, 8'h00, 1'b0);
      owe_byte(PORT_RF, 8'h00, 1'b0);
      owe_byte(PORT_RF, 8'h00, 1'b0);
      owe_byte(PORT_RF, RF_RANGE_CMD ^ RF_SUM_XOR, 1'b1);
      start_wait(PH_RANGE);
    end else if (frame_b[2] == CMD_POINT) begin
      pointer_lit = (frame_b[3] != 8'd0);
      pv = pointer_lit ? PTR_ON_CODE : 8'h00;
      owe_byte(PORT_RF, RF_POINT_CMD, 1'b0);
      owe_byte(PORT_RF, pv, 1'b0);
      owe_byte(PORT_RF, (RF_POINT_CMD + pv) ^ RF_SUM_XOR, 1'b1);
      start_wait(PH_POINT);
    end
  endfunction

  // One byte of the rangefinder answer while an exchange is pending
  function automatic void take_rf_byte(logic [7:0] d);
    logic [4:0]  final_idx;
    logic        ok;
    phase_t      was;
    logic [15:0] dm;
    logic [7:0]  code;
    final_idx = (xchg_phase == PH_RANGE) ? RANGE_LAST_IDX : POINT_LAST_IDX;
    if (rx_count >= final_idx) begin
      ok = rx_good && ((rx_sum ^ RF_SUM_XOR) == d);
      was = xchg_phase;
      xchg_phase = PH_IDLE;
      rx_count = 0;
      if (!ok) return;
      if (was == PH_RANGE) begin
        dm = metres_to_dm(metres_bits);
        if ((rf_status & ST_NO_TARGET) != 8'd0) code = ANS_NO_TARGET;
        else if ((rf_status & ST_ERR_MASK) != 8'd0) code = ANS_ERROR;
        else code = ANS_OK;
        owe_bus_answer(code, CMD_RANGE, dm[7:0], dm[15:8]);
      end else begin
        owe_bus_answer(ANS_OK, CMD_POINT, {7'd0, pointer_lit}, 8'd0);
      end
      return;
    end
    if (rx_count == 0 && d != RF_HDR) rx_good = 1'b0;
    if (xchg_phase == PH_RANGE) begin
      if (rx_count == 1 && d != RF_RANGE_CMD) rx_good = 1'b0;
      if (rx_count >= DIST_FIRST_IDX && rx_count <= DIST_LAST_IDX)
        metres_bits[8*(rx_count-DIST_FIRST_IDX) +: 8] = d;
      if (rx_count == RANGE_STATUS_IDX) rf_status = d;
    end else begin
      if (rx_count == 1 && d != RF_POINT_CMD) rx_good = 1'b0;
      if (rx_count == 2 && d != RF_ACK_TAG) rx_good = 1'b0;
    end
    rx_sum = rx_sum + d;
    rx_count++;
  endfunction

  // Advance the shadow by one accepted transaction
  function automatic void bridge_step(op_t kind, logic [7:0] d, logic idl);
    logic        busy;
    logic        take;
    logic [15:0] limit;
    busy = (xchg_phase == PH_RANGE || xchg_phase == PH_POINT);
    limit = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
    case (kind)
      OP_BUS: begin
        if (bus_fill == 0) sync_seen = (d == BUS_SYNC);
        else frame_b[bus_fill-1] = d;
        bus_fill++;
        if (bus_fill == BUS_FRAME_LEN || idl) begin
          take = (bus_fill == BUS_FRAME_LEN) && sync_seen;
          bus_fill = 0;
          if (take && !busy) accept_command();
        end
      end
      OP_RF: begin
        if (busy) take_rf_byte(d);
      end
      OP_TICK: begin
        if (busy) begin
          if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
          if (tick_count >= limit) begin
            xchg_phase = PH_IDLE;
            rx_count = 0;
          end
        end
      end
      default: bus_fill = 0;
    endcase
  endfunction

  // Stimulus builders
  function automatic void add_item(op_t k, logic [7:0] v, logic idl);
    bridge_item_t it;
    it.kind = k;
    it.value = v;
    it.idle = idl;
    pending_items.push_back(it);
  endfunction

  function automatic void add_frame(logic [7:0] addr, logic [7:0] c1, logic [7:0] c2,
                                    logic [7:0] d1, logic [7:0] d2, logic good_sum,
                                    logic end_idle);
    logic [7:0] ck;
    ck = addr + c1 + c2 + d1 + d2;
    if (!good_sum) ck = ck ^ 8'($urandom_range(1, 255));
    add_item(OP_BUS, BUS_SYNC, 1'b0);
    add_item(OP_BUS, addr, 1'b0);
    add_item(OP_BUS, c1, 1'b0);
    add_item(OP_BUS, c2, 1'b0);
    add_item(OP_BUS, d1, 1'b0);
    add_item(OP_BUS, d2, 1'b0);
    add_item(OP_BUS, ck, end_idle);
  endfunction

  function automatic logic [31:0] pick_metres();
    case ($urandom_range(9))
      0: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      1: return {1'($urandom), 8'hFF, 23'd0};
      2: return {1'($urandom), 31'd0};
      3: return {1'($urandom), 8'h00, 23'($urandom)};
      4: return {1'b1, 8'($urandom_range(100, 160)), 23'($urandom)};
      5: begin
        // values right at the rounding and clamping edges
        case ($urandom_range(7))
          0: return 32'h45CCCC00;
          1: return 32'h45CCCC01;
          2: return 32'h45CCD000;
          3: return 32'h3DCCCCCD;
          4: return 32'h3DCCCCCC;
          5: return 32'h3F800000;
          6: return 32'h7F7FFFFF;
          default: return 32'h00800000;
        endcase
      end
      default: return {1'b0, 8'($urandom_range(115, 142)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] pick_status();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return ST_NO_TARGET;
      2: return ST_FAULT_HI;
      3: return ST_FAULT_LO;
      4: return ST_NO_TARGET | ST_FAULT_LO;
      default: return 8'($urandom);
    endcase
  endfunction

  // Rangefinder answer; now and then spoiled, cut short or laced with ticks
  function automatic void add_reply(logic is_range, int unsigned tick_limit);
    logic [7:0]  msg [22];
    logic [31:0] metres;
    logic [7:0]  sum;
    int unsigned n;
    int unsigned upto;
    int unsigned pos;
    int unsigned tick_pct;
    n = is_range ? 22 : 4;
    sum = '0;
    metres = pick_metres();
    foreach (msg[j]) msg[j] = 8'($urandom);
    msg[0] = RF_HDR;
    if (is_range) begin
      msg[1] = RF_RANGE_CMD;
      for (pos = 0; pos < 4; pos++) msg[DIST_FIRST_IDX+pos] = metres[8*pos +: 8];
      msg[RANGE_STATUS_IDX] = pick_status();
    end else begin
      msg[1] = RF_POINT_CMD;
      msg[2] = RF_ACK_TAG;
    end
    for (pos = 0; pos < n - 1; pos++) sum = sum + msg[pos];
    msg[n-1] = sum ^ RF_SUM_XOR;
    if ($urandom_range(99) < 12) begin
      pos = $urandom_range(0, n - 1);
      msg[pos] = msg[pos] ^ 8'($urandom_range(1, 255));
    end
    upto = n;
    if (tick_limit <= 40 && $urandom_range(99) < 12) upto = $urandom_range(0, n - 1);
    tick_pct = (tick_limit < 4) ? 2 : 6;
    for (pos = 0; pos < upto; pos++) begin
      if ($urandom_range(99) < tick_pct) add_item(OP_TICK, 8'($urandom), 1'($urandom));
      add_item(OP_RF, msg[pos], 1'($urandom));
    end
    if (upto < n)
      repeat ($urandom_range(1, tick_limit + 2)) add_item(OP_TICK, 8'($urandom), 1'($urandom));
  endfunction

  // Request frame and, for a known command, the matching answer
  function automatic void add_exchange(int unsigned tick_limit);
    logic [7:0]  addr;
    logic [7:0]  c2;
    logic [7:0]  d1;
    int unsigned pick;
    addr = ($urandom_range(99) < 85) ? own_addr_q : 8'($urandom);
    pick = $urandom_range(99);
    c2 = (pick < 45) ? CMD_RANGE : (pick < 85) ? CMD_POINT : 8'($urandom);
    d1 = ($urandom_range(1) == 1) ? 8'd0 : 8'($urandom);
    add_frame(addr, 8'($urandom), c2, d1, 8'($urandom), $urandom_range(99) < 90,
              $urandom_range(99) < 80);
    // a second request while the first is pending must be dropped
    if ($urandom_range(99) < 12)
      add_frame(own_addr_q, 8'($urandom), CMD_POINT, 8'($urandom), 8'($urandom), 1'b1,
                1'b1);
    if (c2 == CMD_RANGE || c2 == CMD_POINT) add_reply(c2 == CMD_RANGE, tick_limit);
  endfunction

  // Broken frames and stray transactions; each leaves framing at a boundary
  function automatic void add_noise();
    int unsigned n;
    int unsigned j;
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++)
          add_item(OP_BUS, (j == 0 && $urandom_range(1) == 1) ? BUS_SYNC : 8'($urandom),
                   j == n - 1);
      end
      1: begin
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++) add_item(OP_BUS, (j == 0) ? BUS_SYNC : 8'($urandom), 1'b0);
        add_item(OP_BUS_ERR, 8'($urandom), 1'($urandom));
      end
      2: begin
        add_item(OP_BUS, 8'($urandom_range(0, 254)), 1'b0);
        for (j = 1; j < 7; j++) add_item(OP_BUS, 8'($urandom), (j == 6) && $urandom_range(1));
      end
      default: begin
        case ($urandom_range(2))
          0: add_item(OP_TICK, 8'($urandom), 1'($urandom));
          1: add_item(OP_RF, 8'($urandom), 1'($urandom));
          default: add_item(OP_BUS_ERR, 8'($urandom), 1'($urandom));
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OWN_ADDRESS: own_addr_q = val[7:0];
      REG_TIMEOUT: timeout_q = val;
      default: ;
    endcase
  endtask

  // Wait until every item is taken and every owed byte has come out
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || bytes_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Driver: offer pending items, hold each until its transaction
  always @(posedge clk) begin
    bridge_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bridge_step(op_t'(op), data, bus_idle);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          op <= nxt.kind;
          data <= nxt.value;
          bus_idle <= nxt.idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each output transaction with the oldest owed byte
  always @(posedge clk) begin
    link_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h on port %0d last %0d",
                                  out_byte, port, last));
      end else begin
        want = bytes_due.pop_front();
        if (port !== want.port)
          report_mismatch($sformatf("port %0d, want %0d", port, want.port));
        if (out_byte !== want.value)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.value));
        if (last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", last, want.last));
        bytes_checked++;
        if (want.port == PORT_BUS && want.last) answers_seen++;
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [7:0]  phase_addr [NUM_PHASES];
    logic [15:0] phase_tmo [NUM_PHASES];
    int          ph;
    int unsigned lim;
    phase_addr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h80, OWN_ADDRESS_RST};
    phase_tmo = '{16'd1, 16'hFFFF, 16'd0, 16'd5, 16'($urandom_range(2, 30)), 16'd40};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, pointer exchange, broken frames, strays
    add_frame(OWN_ADDRESS_RST, 8'h00, CMD_POINT, 8'h01, 8'h00, 1'b1, 1'b1);
    add_item(OP_RF, RF_HDR, 1'b0);
    add_item(OP_RF, RF_POINT_CMD, 1'b1);
    add_item(OP_RF, RF_ACK_TAG, 1'b0);
    add_item(OP_RF, (RF_HDR + RF_POINT_CMD + RF_ACK_TAG) ^ RF_SUM_XOR, 1'b0);
    add_item(OP_BUS, BUS_SYNC, 1'b0);
    add_item(OP_BUS, OWN_ADDRESS_RST, 1'b1);
    add_item(OP_BUS, BUS_SYNC, 1'b0);
    add_item(OP_BUS_ERR, 8'hFF, 1'b1);
    add_item(OP_RF, 8'hFF, 1'b1);
    add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_BUS, 8'h00, 1'b0);
    repeat (5) add_item(OP_BUS, 8'hFF, 1'b0);
    add_item(OP_BUS, 8'hFF, 1'b1);
    wait_drained();

    // Random phases, each under its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 74;
        recv_idle_pct = 37;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_OWN_ADDRESS, {8'd0, phase_addr[ph]});
      write_reg(REG_TIMEOUT, phase_tmo[ph]);
      if (ph == 2) write_reg(REG_SPARE_LO, 16'($urandom));
      if (ph == 3) write_reg(REG_SPARE_HI, 16'($urandom));
      settings_run++;
      lim = (timeout_q == 16'd0) ? 1 : timeout_q;
      while (pending_items.size() < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 70) add_exchange(lim);
        else add_noise();
      end
      wait_drained();
    end

    $display("covered %0d input transactions under %0d register settings",
             items_taken, settings_run);
    $display("checked %0d output transactions, %0d of them closing a bus answer",
             bytes_checked, answers_seen);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("timeout: %0d items pending, %0d bytes still owed",
             pending_items.size(), bytes_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
